// ===== hw/rtl/cca_pkg.sv =====
// Shared types, codes and constants of the calibrated color anomaly detector.
// Holds the LED reference tables and the controller/datapath command words.
// No dependencies.
`default_nettype none

package cca_pkg;

    // Field widths
    localparam int POS_W    = 4;
    localparam int LEVEL_W  = 16;
    localparam int LED_W    = 8;
    localparam int CNT_W    = 4;
    localparam int CAL_W    = 8;
    localparam int MARGIN_W = 16;
    localparam int REF_W    = 12;
    // Remainder width of the LED divider: 255 * ref stays below 2^20
    localparam int REM_W    = 20;

    // Stream word widths
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 3;

    // Configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_AW-1:0] CFG_CALIB       = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_LOW_MARGIN  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_HIGH_MARGIN = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_CONFIRM     = 2'd3;

    // Register reset values
    localparam logic [CAL_W-1:0]    CALIB_RST   = 8'd151;
    localparam logic [MARGIN_W-1:0] LOW_RST     = 16'd15;
    localparam logic [MARGIN_W-1:0] HIGH_RST    = 16'd25;
    localparam logic [CNT_W-1:0]    CONFIRM_RST = 4'd3;

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REARM  = 1'b1;

    // Misc constants
    localparam logic [CNT_W-1:0] OUTLIER_MAX = 4'd15;
    localparam logic [CNT_W-1:0] CONFIRM_MIN = 4'd1;
    localparam logic [LED_W-1:0] LED_FULL    = 8'd255;
    localparam logic [POS_W-1:0] LED_LAST    = 4'd10;
    localparam int               LED_TABLE_LEN = 11;
    localparam int               DIV_STEPS   = 8;

    // Channel select codes
    typedef logic [1:0] t_chan;
    localparam t_chan CH_RED   = 2'd0;
    localparam t_chan CH_GREEN = 2'd1;
    localparam t_chan CH_BLUE  = 2'd2;

    // LED full-scale reference per position
    localparam logic [REF_W-1:0] LED_REF_RED [LED_TABLE_LEN] = '{
        12'd610, 12'd811, 12'd1153, 12'd1753, 12'd1983, 12'd2143,
        12'd2248, 12'd2299, 12'd2232, 12'd1913, 12'd1327};
    localparam logic [REF_W-1:0] LED_REF_GREEN [LED_TABLE_LEN] = '{
        12'd704, 12'd946, 12'd1343, 12'd2175, 12'd2537, 12'd2805,
        12'd2987, 12'd3082, 12'd2949, 12'd2407, 12'd1595};
    localparam logic [REF_W-1:0] LED_REF_BLUE [LED_TABLE_LEN] = '{
        12'd601, 12'd837, 12'd1215, 12'd1921, 12'd2237, 12'd2470,
        12'd2628, 12'd2711, 12'd2597, 12'd2124, 12'd1411};

    // Reference lookup; positions past the table use its last entry
    function automatic logic [REF_W-1:0] led_ref(input t_chan ch, input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] idx;
        logic [REF_W-1:0] res;
        idx = (pos > LED_LAST) ? LED_LAST : pos;
        case (ch)
            CH_RED:   res = LED_REF_RED[idx];
            CH_GREEN: res = LED_REF_GREEN[idx];
            default:  res = LED_REF_BLUE[idx];
        endcase
        return res;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic  load_in;
        logic  rd_mem;
        logic  eval;
        logic  div_init;
        logic  div_step;
        logic  div_store;
        t_chan chan;
        logic  out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic hit;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/cca_div.sv =====
// Shared LED level divider: 255 - ceil(v*255/ref), saturated at zero.
// Restoring division, one quotient bit per step. Uses cca_pkg.
`default_nettype none

module cca_div
    import cca_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_init,
    input  wire logic                   i_step,
    input  wire logic [SAMPLE_BITS-1:0] i_level,
    input  wire logic [REF_W-1:0]       i_ref,
    output logic      [LED_W-1:0]       o_led
);

    // Numerator v*255 + ref - 1 needs SAMPLE_BITS + 9 bits
    localparam int NUM_W = SAMPLE_BITS + LED_W + 1;
    localparam int CW    = (NUM_W > REM_W) ? NUM_W : REM_W;

    logic [CW-1:0]     w_num;
    logic [CW-1:0]     w_lim;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_den;
    logic [LED_W-1:0]  r_q;
    logic              r_sat;

    // Ceiling numerator and saturation limit, shifts and adds only
    assign w_num = (CW'(i_level) << LED_W) - CW'(i_level) + CW'(i_ref) - CW'(1);
    assign w_lim = (CW'(i_ref) << LED_W) - CW'(i_ref);

    // One quotient bit per step, divisor walks down from ref << 7
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_sat <= (w_num >= w_lim);
            r_rem <= w_num[REM_W-1:0];
            r_den <= REM_W'(i_ref) << (DIV_STEPS - 1);
            r_q   <= '0;
        end else if (i_step) begin
            if (r_rem >= r_den) begin
                r_rem <= r_rem - r_den;
                r_q   <= {r_q[LED_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[LED_W-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
        end
    end

    assign o_led = r_sat ? '0 : (LED_FULL - r_q);

endmodule

`default_nettype wire

// ===== hw/rtl/cca_ctrl.sv =====
// Sequencer of the anomaly detector: accept, range read, evaluate,
// three LED divisions on a find, then hand-off to the output register. Uses cca_pkg.
`default_nettype none

module cca_ctrl
    import cca_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_EVAL   = 7'b0000100,
        S_DINIT  = 7'b0001000,
        S_DSTEP  = 7'b0010000,
        S_DSTORE = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    t_chan             r_chan, n_chan;
    logic [STEP_W-1:0] r_step, n_step;

    // State, channel and step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= CH_RED;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_step  <= n_step;
        end
    end

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.chan = r_chan;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_mem = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_chan = CH_RED;
                n_state = i_status.hit ? S_DINIT : S_RESULT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_step = '0;
                n_state = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_DSTORE;
                end
            end
            S_DSTORE: begin
                o_cmd.div_store = 1'b1;
                if (r_chan == CH_BLUE) begin
                    n_state = S_RESULT;
                end else begin
                    n_chan = r_chan + t_chan'(1);
                    n_state = S_DINIT;
                end
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cca_dp.sv =====
// Datapath of the anomaly detector: configuration registers, per-position
// range memory, in-range test, counters, LED divider and output register.
// Uses cca_pkg and cca_div.
`default_nettype none

module cca_dp
    import cca_pkg::*;
#(
    parameter int NUM_POSITIONS = 11,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_AW-1:0]      i_cfg_addr,
    input  wire logic [CFG_DW-1:0]      i_cfg_data,
    // input word
    input  wire logic [IN_TDATA_W-1:0]  i_in_data,
    input  wire logic [IN_TUSER_W-1:0]  i_in_user,
    // output word
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [OUT_TDATA_W-1:0] o_out_data,
    output logic      [OUT_TUSER_W-1:0] o_out_user,
    // control
    input  wire t_cmd                   i_cmd,
    output t_status                     o_status
);

    localparam int SB      = SAMPLE_BITS;
    localparam int AW      = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
    localparam int ENTRY_W = 6 * SB;
    localparam int RW      = ((SB > MARGIN_W) ? SB : MARGIN_W) + 1;
    localparam int CMP_W   = 8;

    // Configuration registers
    logic [CAL_W-1:0]    r_cfg_calib;
    logic [MARGIN_W-1:0] r_cfg_low;
    logic [MARGIN_W-1:0] r_cfg_high;
    logic [CNT_W-1:0]    r_cfg_confirm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_calib   <= CALIB_RST;
            r_cfg_low     <= LOW_RST;
            r_cfg_high    <= HIGH_RST;
            r_cfg_confirm <= CONFIRM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CALIB:       r_cfg_calib   <= i_cfg_data[CAL_W-1:0];
                CFG_LOW_MARGIN:  r_cfg_low     <= i_cfg_data[MARGIN_W-1:0];
                CFG_HIGH_MARGIN: r_cfg_high    <= i_cfg_data[MARGIN_W-1:0];
                CFG_CONFIRM:     r_cfg_confirm <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input word capture; levels keep their low SAMPLE_BITS bits
    logic              r_cmd;
    logic [POS_W-1:0]  r_pos;
    logic [SB-1:0]     r_lvl [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd    <= i_in_user[0];
            r_pos    <= i_in_data[POS_W-1:0];
            r_lvl[0] <= i_in_data[POS_W +: SB];
            r_lvl[1] <= i_in_data[POS_W + LEVEL_W +: SB];
            r_lvl[2] <= i_in_data[POS_W + 2*LEVEL_W +: SB];
        end
    end

    // Range memory address
    logic [POS_W+AW-1:0] w_pos_wide;
    logic [AW-1:0]       w_addr;
    logic                w_pos_ok;

    assign w_pos_wide = {{AW{1'b0}}, r_pos};
    assign w_addr     = w_pos_wide[AW-1:0];
    assign w_pos_ok   = ({{(CMP_W-POS_W){1'b0}}, r_pos} < CMP_W'(NUM_POSITIONS));

    // Range memory: {high blue..red, low blue..red}, registered read
    logic [ENTRY_W-1:0]       mem [NUM_POSITIONS];
    logic [ENTRY_W-1:0]       r_rd;
    logic [ENTRY_W-1:0]       w_wdata;
    logic                     w_we;
    logic [NUM_POSITIONS-1:0] r_valid;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && w_we) begin
            mem[w_addr] <= w_wdata;
        end
        if (i_cmd.rd_mem) begin
            r_rd       <= mem[w_addr];
            r_rd_valid <= r_valid[w_addr];
        end
    end

    // Entry written marks; unwritten entries read as the reset ranges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.eval && w_we) begin
            r_valid[w_addr] <= 1'b1;
        end
    end

    // Per-channel range test and widened ranges
    logic [SB-1:0] w_lo [3];
    logic [SB-1:0] w_hi [3];
    logic [2:0]    w_ok;
    logic          w_in_range;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_lo[c] = r_rd_valid ? r_rd[c*SB +: SB] : {SB{1'b1}};
            w_hi[c] = r_rd_valid ? r_rd[(3+c)*SB +: SB] : {SB{1'b0}};
            w_ok[c] = ((RW'(r_lvl[c]) + RW'(r_cfg_low)) > RW'(w_lo[c]))
                   && (RW'(r_lvl[c]) < (RW'(w_hi[c]) + RW'(r_cfg_high)));
            w_wdata[c*SB +: SB]     = (r_lvl[c] < w_lo[c]) ? r_lvl[c] : w_lo[c];
            w_wdata[(3+c)*SB +: SB] = (r_lvl[c] > w_hi[c]) ? r_lvl[c] : w_hi[c];
        end
    end
    assign w_in_range = &w_ok;

    // Detection state
    logic [CAL_W-1:0] r_calib, n_calib;
    logic [CNT_W-1:0] r_outlier, n_outlier;
    logic             r_detect, n_detect;
    logic [CNT_W-1:0] w_need;
    logic [CNT_W-1:0] w_oc_inc;
    logic             w_calib_act;
    logic             w_hit;

    assign w_need      = (r_cfg_confirm == '0) ? CONFIRM_MIN : r_cfg_confirm;
    assign w_oc_inc    = (r_outlier < OUTLIER_MAX) ? (r_outlier + CNT_W'(1)) : r_outlier;
    assign w_calib_act = (r_calib < r_cfg_calib);

    // Item decision
    always_comb begin
        n_calib   = r_calib;
        n_outlier = r_outlier;
        n_detect  = r_detect;
        w_we      = 1'b0;
        w_hit     = 1'b0;
        if (r_cmd == CMD_REARM) begin
            if (!w_calib_act) begin
                n_detect = 1'b1;
            end
        end else if (w_pos_ok) begin
            if (w_calib_act) begin
                w_we    = 1'b1;
                n_calib = r_calib + CAL_W'(1);
                if (n_calib >= r_cfg_calib) begin
                    n_detect = 1'b1;
                end
            end else if (r_detect) begin
                if (w_in_range) begin
                    n_outlier = '0;
                    w_we      = 1'b1;
                end else if (w_oc_inc >= w_need) begin
                    w_hit     = 1'b1;
                    n_outlier = '0;
                    n_detect  = 1'b0;
                end else begin
                    n_outlier = w_oc_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib   <= '0;
            r_outlier <= '0;
            r_detect  <= 1'b0;
        end else if (i_cmd.eval) begin
            r_calib   <= n_calib;
            r_outlier <= n_outlier;
            r_detect  <= n_detect;
        end
    end

    // LED divider, shared by the three channels
    logic [SB-1:0]    w_div_level;
    logic [REF_W-1:0] w_div_ref;
    logic [LED_W-1:0] w_div_led;

    always_comb begin
        case (i_cmd.chan)
            CH_RED:   w_div_level = r_lvl[0];
            CH_GREEN: w_div_level = r_lvl[1];
            default:  w_div_level = r_lvl[2];
        endcase
    end
    assign w_div_ref = led_ref(i_cmd.chan, r_pos);

    cca_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_init  (i_cmd.div_init),
        .i_step  (i_cmd.div_step),
        .i_level (w_div_level),
        .i_ref   (w_div_ref),
        .o_led   (w_div_led)
    );

    // Result fields of the current item
    logic             r_res_found;
    logic             r_res_calib;
    logic             r_res_armed;
    logic [LED_W-1:0] r_led [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_res_found <= w_hit;
            r_res_calib <= (n_calib < r_cfg_calib);
            r_res_armed <= n_detect;
            r_led[0]    <= '0;
            r_led[1]    <= '0;
            r_led[2]    <= '0;
        end else if (i_cmd.div_store) begin
            case (i_cmd.chan)
                CH_RED:   r_led[0] <= w_div_led;
                CH_GREEN: r_led[1] <= w_div_led;
                default:  r_led[2] <= w_div_led;
            endcase
        end
    end

    // Output register; the next item runs while a word waits here
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_led[2], r_led[1], r_led[0]};
            r_out_user <= {r_res_armed, r_res_calib, r_res_found};
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_out_user        = r_out_user;
    assign o_status.hit      = w_hit;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/calibrated_color_anomaly_detector.sv =====
// Calibrated color anomaly detector, top level. An accepted item passes range
// read and evaluation to the output register; an item that confirms a find
// first runs three LED divisions on the shared 8-step divider.
// One item is in work at a time; an item is accepted while the previous word
// still waits in the output register, and the hand-off waits until it is free.
// Synchronous active-low reset restores register defaults and empty ranges.
`default_nettype none

module calibrated_color_anomaly_detector
    import cca_pkg::*;
#(
    parameter int NUM_POSITIONS = 11,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_AW-1:0]      i_cfg_addr,
    input  wire logic [CFG_DW-1:0]      i_cfg_data,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [3:0] position, [19:4] red_level, [35:20] green_level,
    // [51:36] blue_level, [55:52] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // output stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [7:0] led_red, [15:8] led_green, [23:16] led_blue
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] found, [1] calibrating, [2] armed
    output logic      [OUT_TUSER_W-1:0] m_axis_tuser
);

    t_cmd    w_cmd;
    t_status w_status;

    cca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cca_dp #(
        .NUM_POSITIONS (NUM_POSITIONS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

`default_nettype wire

// ===== test/calibrated_color_anomaly_detector_test.sv =====
// Self-checking bench for calibrated_color_anomaly_detector: a directed table and then
// random phases, each word checked against an in-bench model of ranges, counters and LEDs.
// Depends on cca_pkg and the detector RTL only.
module calibrated_color_anomaly_detector_test;
    import cca_pkg::*;

    localparam int NUM_POS         = 11;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 82;
    localparam int CYCLE_LIMIT     = 600000;

    // LED full-scale values per position
    localparam int FS_RED [NUM_POS] = '{610, 811, 1153, 1753, 1983, 2143,
                                        2248, 2299, 2232, 1913, 1327};
    localparam int FS_GREEN [NUM_POS] = '{704, 946, 1343, 2175, 2537, 2805,
                                          2987, 3082, 2949, 2407, 1595};
    localparam int FS_BLUE [NUM_POS] = '{601, 837, 1215, 1921, 2237, 2470,
                                         2628, 2711, 2597, 2124, 1411};

    typedef struct packed {
        logic       found;
        logic       calibrating;
        logic       armed;
        logic [7:0] led_red;
        logic [7:0] led_green;
        logic [7:0] led_blue;
    } t_verdict;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              cmd;
        logic [3:0]        pos;
        logic [15:0]       red;
        logic [15:0]       green;
        logic [15:0]       blue;
        logic [CFG_AW-1:0] reg_idx;
        logic [CFG_DW-1:0] reg_val;
        logic              typed;
        t_verdict          want;
    } t_row;

    localparam t_verdict V_NONE        = '0;
    localparam t_verdict V_IDLE        = '{1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0};
    localparam t_verdict V_CALIBRATING = '{1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0};
    localparam t_verdict V_ARMED       = '{1'b0, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0};
    localparam t_verdict V_FIND_DARK   = '{1'b1, 1'b0, 1'b0, 8'd255, 8'd255, 8'd255};
    localparam t_verdict V_FIND_BRIGHT = '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0};

    localparam int DIR_ROWS = 27;

    // Directed table: typed expectations where obvious, the rest from the model
    localparam t_row DIRECTED [DIR_ROWS] = '{
        // rearm before calibration is ignored
        '{ROW_ITEM, CMD_REARM,  4'd0,  16'd0, 16'd0, 16'd0, CFG_CALIB, 16'd0, 1'b1, V_CALIBRATING},
        // position out of range changes nothing
        '{ROW_ITEM, CMD_SAMPLE, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, CFG_CALIB, 16'd0, 1'b1,
          V_CALIBRATING},
        '{ROW_CFG,  CMD_SAMPLE, 4'd0,  16'd0, 16'd0, 16'd0, CFG_CALIB,   16'd2, 1'b0, V_NONE},
        '{ROW_CFG,  CMD_SAMPLE, 4'd0,  16'd0, 16'd0, 16'd0, CFG_CONFIRM, 16'd1, 1'b0, V_NONE},
        // two calibration words, then armed
        '{ROW_ITEM, CMD_SAMPLE, 4'd0, 16'd100, 16'd120, 16'd140, CFG_CALIB, 16'd0, 1'b1,
          V_CALIBRATING},
        '{ROW_ITEM, CMD_SAMPLE, 4'd0, 16'd300, 16'd320, 16'd340, CFG_CALIB, 16'd0, 1'b1, V_ARMED},
        '{ROW_ITEM, CMD_SAMPLE, 4'd0, 16'd200, 16'd220, 16'd240, CFG_CALIB, 16'd0, 1'b1, V_ARMED},
        // zero levels: find with full LEDs
        '{ROW_ITEM, CMD_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, CFG_CALIB, 16'd0, 1'b1, V_FIND_DARK},
        // disarmed after the find
        '{ROW_ITEM, CMD_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, CFG_CALIB, 16'd0, 1'b1, V_IDLE},
        '{ROW_ITEM, CMD_REARM,  4'd9, 16'hFFFF, 16'd0, 16'hFFFF, CFG_CALIB, 16'd0, 1'b1, V_ARMED},
        // full-scale levels: LEDs saturate to zero
        '{ROW_ITEM, CMD_SAMPLE, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, CFG_CALIB, 16'd0, 1'b1,
          V_FIND_BRIGHT},
        '{ROW_ITEM, CMD_REARM,  4'd0, 16'd0, 16'd0, 16'd0, CFG_CALIB, 16'd0, 1'b1, V_ARMED},
        // never-calibrated last position
        '{ROW_ITEM, CMD_SAMPLE, 4'd10, 16'd500, 16'd700, 16'd900, CFG_CALIB, 16'd0, 1'b0, V_NONE},
        // confirm count zero acts as one
        '{ROW_CFG,  CMD_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, CFG_CONFIRM, 16'd0, 1'b0, V_NONE},
        '{ROW_ITEM, CMD_REARM,  4'd0, 16'd0, 16'd0, 16'd0, CFG_CALIB, 16'd0, 1'b0, V_NONE},
        '{ROW_ITEM, CMD_SAMPLE, 4'd7, 16'd1234, 16'd2345, 16'd3456, CFG_CALIB, 16'd0, 1'b0,
          V_NONE},
        // raise calibration length, calibrate once, then lower it below the count
        '{ROW_CFG,  CMD_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, CFG_CALIB, 16'd255, 1'b0, V_NONE},
        '{ROW_ITEM, CMD_SAMPLE, 4'd1, 16'd40000, 16'd50000, 16'd60000, CFG_CALIB, 16'd0, 1'b1,
          V_CALIBRATING},
        '{ROW_CFG,  CMD_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, CFG_CALIB, 16'd1, 1'b0, V_NONE},
        // complete but still disarmed until a rearm
        '{ROW_ITEM, CMD_SAMPLE, 4'd1, 16'd0, 16'd0, 16'd0, CFG_CALIB, 16'd0, 1'b1, V_IDLE},
        // widest margins, longest confirm
        '{ROW_CFG,  CMD_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, CFG_LOW_MARGIN, 16'hFFFF, 1'b0,
          V_NONE},
        '{ROW_CFG,  CMD_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, CFG_HIGH_MARGIN, 16'hFFFF, 1'b0,
          V_NONE},
        '{ROW_CFG,  CMD_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, CFG_CONFIRM, 16'd15, 1'b0, V_NONE},
        '{ROW_ITEM, CMD_REARM,  4'd0, 16'd0, 16'd0, 16'd0, CFG_CALIB, 16'd0, 1'b1, V_ARMED},
        '{ROW_ITEM, CMD_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, CFG_CALIB, 16'd0, 1'b0, V_NONE},
        '{ROW_ITEM, CMD_SAMPLE, 4'd3, 16'hFFFF, 16'd0, 16'hFFFF, CFG_CALIB, 16'd0, 1'b0, V_NONE},
        '{ROW_ITEM, CMD_SAMPLE, 4'd0, 16'hFFFF, 16'h8000, 16'h0001, CFG_CALIB, 16'd0, 1'b0,
          V_NONE}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_AW-1:0]      i_cfg_addr;
    logic [CFG_DW-1:0]      i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [3:0] position, [19:4] red, [35:20] green, [51:36] blue, [55:52] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // [0] command
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [7:0] led_red, [15:8] led_green, [23:16] led_blue
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] found, [1] calibrating, [2] armed
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // Model state and register shadows
    int span_lo [NUM_POS][3];
    int span_hi [NUM_POS][3];
    int center  [NUM_POS][3];
    int calib_count;
    int outlier_count;
    bit detect_on;
    int calib_len;
    int low_margin;
    int high_margin;
    int confirm_need;
    int outlier_burst;

    t_verdict    verdicts_due [$];
    int          mismatches;
    int unsigned cycle_count;

    calibrated_color_anomaly_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Cycle count and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Idle-free stretch: one window in five
    function automatic bit calm_window();
        return (cycle_count / 2000) % 5 == 4;
    endfunction

    // Receiver stalls
    always @(posedge i_clk) begin
        m_axis_tready <= calm_window() || ($urandom_range(0, 99) >= 10);
    end

    // LED level: 255 - ceil(v*255/fs), floored at zero
    function automatic logic [7:0] led_duty(input int v, input int fs);
        longint q;
        q = (longint'(v) * 255 + fs - 1) / fs;
        return (q >= 255) ? 8'd0 : 8'(255 - q);
    endfunction

    function automatic void widen_span(input int pos, input int lv [3]);
        for (int c = 0; c < 3; c++) begin
            if (lv[c] < span_lo[pos][c]) span_lo[pos][c] = lv[c];
            if (lv[c] > span_hi[pos][c]) span_hi[pos][c] = lv[c];
        end
    endfunction

    // Detector model: advances state for one accepted word, returns its verdict
    function automatic t_verdict judge_sample(input logic cmd, input logic [3:0] pos,
                                              input logic [15:0] r, g, b);
        t_verdict v;
        int       lv [3];
        int       need;
        bit       fits;
        v = '0;
        lv[0] = int'(r);
        lv[1] = int'(g);
        lv[2] = int'(b);
        need = (confirm_need == 0) ? 1 : confirm_need;
        if (cmd == CMD_REARM) begin
            if (calib_count >= calib_len) detect_on = 1'b1;
        end else if (pos < NUM_POS) begin
            if (calib_count < calib_len) begin
                widen_span(pos, lv);
                calib_count++;
                if (calib_count >= calib_len) detect_on = 1'b1;
            end else if (detect_on) begin
                fits = 1'b1;
                for (int c = 0; c < 3; c++) begin
                    if (!(lv[c] > span_lo[pos][c] - low_margin &&
                          lv[c] < span_hi[pos][c] + high_margin)) fits = 1'b0;
                end
                if (fits) begin
                    outlier_count = 0;
                    widen_span(pos, lv);
                end else begin
                    if (outlier_count < 15) outlier_count++;
                    if (outlier_count >= need) begin
                        v.found = 1'b1;
                        outlier_count = 0;
                        detect_on = 1'b0;
                        v.led_red   = led_duty(lv[0], FS_RED[pos]);
                        v.led_green = led_duty(lv[1], FS_GREEN[pos]);
                        v.led_blue  = led_duty(lv[2], FS_BLUE[pos]);
                    end
                end
            end
        end
        v.calibrating = (calib_count < calib_len);
        v.armed = detect_on;
        return v;
    endfunction

    // Drive one word; predict and queue its verdict once it is taken
    task automatic send_item(input logic cmd, input logic [3:0] pos,
                             input logic [15:0] r, g, b,
                             input bit typed, input t_verdict typed_want);
        int       gap;
        t_verdict v;
        gap = 0;
        if (!calm_window()) while ($urandom_range(0, 99) < 10) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, b, g, r, pos};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        v = judge_sample(cmd, pos, r, g, b);
        verdicts_due.push_back(typed ? typed_want : v);
    endtask

    // Stop offering words and wait for every pending result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_CALIB:       calib_len    = int'(val[7:0]);
            CFG_LOW_MARGIN:  low_margin   = int'(val);
            CFG_HIGH_MARGIN: high_margin  = int'(val);
            CFG_CONFIRM:     confirm_need = int'(val[3:0]);
            default: ;
        endcase
    endtask

    function automatic int pick_margin();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 40);
            1:       return $urandom_range(0, 400);
            2:       return $urandom_range(0, 65535);
            default: return 0;
        endcase
    endfunction

    // New register set per phase; first two phases take the extremes
    task automatic program_phase(input int ph);
        int          cal;
        int          lo_m;
        int          hi_m;
        int          conf;
        logic [15:0] junk;
        junk = 16'($urandom());
        if (ph == 0) begin
            cal = 1; lo_m = 0; hi_m = 0; conf = 1;
        end else if (ph == 1) begin
            cal = calib_count; lo_m = 65535; hi_m = 65535; conf = 15;
        end else begin
            cal = calib_count + $urandom_range(0, 25);
            if ($urandom_range(0, 99) < 30) cal = $urandom_range(1, 255);
            lo_m = pick_margin();
            hi_m = pick_margin();
            conf = $urandom_range(0, 15);
        end
        if (ph == PHASES - 1) cal = 255;
        if (cal > 255) cal = 255;
        if (cal < 1) cal = 1;
        drain();
        // unused upper data bits carry noise
        write_reg(CFG_CALIB, {junk[15:8], 8'(cal)});
        write_reg(CFG_LOW_MARGIN, 16'(lo_m));
        write_reg(CFG_HIGH_MARGIN, 16'(hi_m));
        write_reg(CFG_CONFIRM, {junk[11:0], 4'(conf)});
    endtask

    // Mostly well-formed traffic around the learned ranges, with outlier bursts
    task automatic random_item();
        int   roll;
        int   pos;
        int   need;
        int   odd_ch;
        int   lo_edge;
        int   hi_edge;
        int   lv [3];
        logic cmd;
        roll = $urandom_range(0, 99);
        cmd = CMD_SAMPLE;
        pos = $urandom_range(0, NUM_POS - 1);
        need = (confirm_need == 0) ? 1 : confirm_need;
        for (int c = 0; c < 3; c++) lv[c] = $urandom_range(0, 65535);
        if ((calib_count >= calib_len && !detect_on && roll < 50) || roll < 4) begin
            cmd = CMD_REARM;
        end else if (roll < 10) begin
            pos = $urandom_range(NUM_POS, 15);
        end else if (roll >= 18) begin
            for (int c = 0; c < 3; c++) begin
                if (calib_count >= calib_len && span_lo[pos][c] <= span_hi[pos][c])
                    lv[c] = $urandom_range(span_lo[pos][c], span_hi[pos][c]);
                else
                    lv[c] = center[pos][c] + $urandom_range(0, 600) - 300;
            end
            if (calib_count >= calib_len) begin
                if (outlier_burst == 0 && $urandom_range(0, 99) < 15)
                    outlier_burst = $urandom_range(1, need + 1);
                if (outlier_burst > 0) begin
                    outlier_burst--;
                    odd_ch = $urandom_range(0, 2);
                    lo_edge = span_lo[pos][odd_ch] - low_margin;
                    hi_edge = span_hi[pos][odd_ch] + high_margin;
                    // land on the boundary now and then
                    if (hi_edge <= 65535 && (lo_edge < 0 || $urandom_range(0, 1)))
                        lv[odd_ch] = ($urandom_range(0, 3) == 0) ? hi_edge
                                                                 : $urandom_range(hi_edge, 65535);
                    else if (lo_edge >= 0)
                        lv[odd_ch] = ($urandom_range(0, 3) == 0) ? lo_edge
                                                                 : $urandom_range(0, lo_edge);
                end
            end
        end
        send_item(cmd, 4'(pos), 16'(lv[0]), 16'(lv[1]), 16'(lv[2]), 1'b0, V_NONE);
    endtask

    // Output checker
    always @(posedge i_clk) begin : check_words
        t_verdict got;
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2],
                    m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]};
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: found=%0d cal=%0d armed=%0d led=%0d/%0d/%0d",
                             got.found, got.calibrating, got.armed,
                             got.led_red, got.led_green, got.led_blue);
            end else begin
                want = verdicts_due.pop_front();
                if (got.found !== want.found || got.calibrating !== want.calibrating ||
                    got.armed !== want.armed || got.led_red !== want.led_red ||
                    got.led_green !== want.led_green || got.led_blue !== want.led_blue) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp found=%0d cal=%0d armed=%0d led=%0d/%0d/%0d",
                                  " got found=%0d cal=%0d armed=%0d led=%0d/%0d/%0d"},
                                 want.found, want.calibrating, want.armed,
                                 want.led_red, want.led_green, want.led_blue,
                                 got.found, got.calibrating, got.armed,
                                 got.led_red, got.led_green, got.led_blue);
                end
            end
        end
    end

    // Stimulus
    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b1;
        cycle_count   = 0;
        mismatches    = 0;
        outlier_burst = 0;
        calib_count   = 0;
        outlier_count = 0;
        detect_on     = 1'b0;
        calib_len     = 151;
        low_margin    = 15;
        high_margin   = 25;
        confirm_need  = 3;
        for (int p = 0; p < NUM_POS; p++) begin
            for (int c = 0; c < 3; c++) begin
                span_lo[p][c] = 65535;
                span_hi[p][c] = 0;
                center[p][c]  = $urandom_range(2000, 60000);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].kind == ROW_CFG) begin
                drain();
                write_reg(DIRECTED[k].reg_idx, DIRECTED[k].reg_val);
            end else begin
                send_item(DIRECTED[k].cmd, DIRECTED[k].pos, DIRECTED[k].red,
                          DIRECTED[k].green, DIRECTED[k].blue,
                          DIRECTED[k].typed, DIRECTED[k].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            program_phase(ph);
            repeat (ITEMS_PER_PHASE) random_item();
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cca_pkg.sv
hw/rtl/cca_div.sv
hw/rtl/cca_ctrl.sv
hw/rtl/cca_dp.sv
hw/rtl/calibrated_color_anomaly_detector.sv
test/calibrated_color_anomaly_detector_test.sv
